// ===== design/jtok_pkg.sv =====
// Package for the streaming JSON tokenizer: codes, field widths, stack entry type.
// No dependencies; used by every module of the block.
package jtok_pkg;

    localparam int DefMaxTokens = 128;
    localparam int DefMaxDepth  = 16;

    localparam logic [15:0] POS_LIMIT = 16'hFFFF;

    typedef enum logic [5:0] {
        M_NORMAL = 6'b000001,
        M_STRING = 6'b000010,
        M_ESCAPE = 6'b000100,
        M_PRIM   = 6'b001000,
        M_ERR_IN = 6'b010000,
        M_ERR_NM = 6'b100000
    } mode_t;

    localparam logic [2:0] K_TOKEN = 3'd0;
    localparam logic [2:0] K_OK    = 3'd1;
    localparam logic [2:0] K_INVAL = 3'd2;
    localparam logic [2:0] K_PART  = 3'd3;
    localparam logic [2:0] K_NOMEM = 3'd4;

    localparam logic [1:0] T_OBJECT = 2'd0;
    localparam logic [1:0] T_ARRAY  = 2'd1;
    localparam logic [1:0] T_STRING = 2'd2;
    localparam logic [1:0] T_PRIM   = 2'd3;

    localparam logic [7:0] NO_PARENT = 8'hFF;

    // One result record
    typedef struct packed {
        logic [2:0]  kind;
        logic [6:0]  token_index;
        logic [1:0]  token_type;
        logic [15:0] token_start;
        logic [15:0] token_end;
        logic [6:0]  child_count;
        logic [7:0]  parent_index;
        logic        last_of_run;
    } rec_t;

    // Open container entry
    typedef struct packed {
        logic [7:0]  idx;
        logic        is_array;
        logic [6:0]  cnt;
        logic [15:0] start;
    } entry_t;

    // Stack operation from the scanner to the cell row
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   bump;
        logic   clear;
        entry_t push_entry;
    } stk_op_t;

endpackage

// ===== design/jtok_cell.sv =====
// One cell of the open-container stack: holds one entry and shifts with its neighbors.
// Depends on jtok_pkg.
module jtok_cell
    import jtok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stk_op_t op,
    input  entry_t  from_above,
    input  logic    above_valid,
    input  entry_t  from_below,
    input  logic    below_valid,
    output entry_t  entry,
    output logic    valid
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    // Clear empties the cell; else shift down on push, up on pop, bump count of the parent cell
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (op.clear)
        begin
            valid_next = 1'b0;
        end
        else if (op.push)
        begin
            entry_next = from_above;
            valid_next = above_valid;
            if (op.bump && above_valid && entry_next.cnt != 7'd127)
            begin
                entry_next.cnt = entry_next.cnt + 7'd1;
            end
        end
        else if (op.pop)
        begin
            entry_next = from_below;
            valid_next = below_valid;
        end
        else if (op.bump && valid_reg && entry_reg.cnt != 7'd127)
        begin
            entry_next.cnt = entry_reg.cnt + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// ===== design/jtok_stack.sv =====
// Row of stack cells; the top of stack is always cell 0.
// Depends on jtok_pkg and jtok_cell.
module jtok_stack
    import jtok_pkg::*;
#(
    parameter int MAX_DEPTH = DefMaxDepth
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  stk_op_t op,
    output entry_t  top,
    output logic    top_valid,
    output entry_t  under,
    output logic    under_valid,
    output logic    full
);

    // Cell 0 is the top; push shifts toward higher cells
    entry_t ent [MAX_DEPTH];
    logic   vld [MAX_DEPTH];

    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        entry_t a_e, b_e;
        logic   a_v, b_v;
        if (i == 0)
        begin : g_top
            assign a_e = op.push_entry;
            assign a_v = 1'b1;
        end
        else
        begin : g_mid
            assign a_e = ent[i-1];
            assign a_v = vld[i-1];
        end
        if (i == MAX_DEPTH - 1)
        begin : g_bot
            assign b_e = ent[i];
            assign b_v = 1'b0;
        end
        else
        begin : g_nbot
            assign b_e = ent[i+1];
            assign b_v = vld[i+1];
        end
        // Bump rides on the cell that holds the parent after the shift
        stk_op_t cop;
        always_comb
        begin
            cop = op;
            // on push the old top moves to cell 1; without a shift it stays in cell 0
            cop.bump = op.bump && ((op.push && i == 1) || (!op.push && !op.pop && i == 0));
        end
        jtok_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (cop),
            .from_above (a_e),
            .above_valid(a_v),
            .from_below (b_e),
            .below_valid(b_v),
            .entry      (ent[i]),
            .valid      (vld[i])
        );
    end

    assign top         = ent[0];
    assign top_valid   = vld[0];
    assign under       = ent[1];
    assign under_valid = vld[1];
    assign full        = vld[MAX_DEPTH-1];

endmodule

// ===== design/json_tokenizer.sv =====
// Top level of the streaming JSON tokenizer: byte scanner, stack row, result queue.
// Depends on jtok_pkg, jtok_stack.
//
// Usage: bytes enter on s_axis (tdata = text_byte, tlast = last_byte), one per
// cycle while s_axis_tready is high. Each byte yields zero to three result items
// on m_axis; tlast marks the final item caused by a byte. tuser carries kind;
// tdata the token fields. A byte is scanned in the cycle it is accepted; its
// results enter the result queue at that edge and can appear on m_axis from the
// next cycle, one item per cycle while m_axis_tready is high. Throughput is one
// byte per cycle while bytes yield at most one result and the receiver keeps up;
// extra results queue for the single output port. Containers open on a row of
// cells that shift on push and pop, so the top entry is always in the first cell.
// The user must write strict_mode on cfg_valid/cfg_ready only while idle; the
// block does not enforce this. Reset clears the scanner, the stack row and the
// result queue; strict_mode returns to 0. When the receiver stalls, results wait
// in a small queue and s_axis_tready drops once it cannot take a worst-case byte.
module json_tokenizer
    import jtok_pkg::*;
#(
    parameter int MAX_TOKENS = DefMaxTokens,
    parameter int MAX_DEPTH  = DefMaxDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [6:0] token_index, [8:7] token_type, [24:9] token_start, [40:25] token_end,
    // [47:41] child_count, [55:48] parent_index, [63:56] zero fill
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam int QD = 8;
    localparam int QW = $clog2(QD);

    mode_t        mode_reg, mode_next;
    logic [15:0]  pos_reg, pos_next, pend_reg, pend_next;
    logic [TW-1:0] used_reg, used_next;
    logic         strict_reg;
    stk_op_t      op;
    entry_t       top, under;
    logic         top_valid, under_valid, full;

    jtok_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .clk(clk), .rst_n(rst_n), .op(op), .top(top), .top_valid(top_valid),
        .under(under), .under_valid(under_valid), .full(full)
    );

    // Configuration
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            strict_reg <= cfg_data;
        end
    end

    // Result queue
    rec_t          q [QD];
    logic [QW-1:0] wp_reg, rp_reg;
    logic [QW:0]   cnt_reg;
    rec_t          r [3];
    logic [1:0]    nres;
    logic          take, pop_q;

    assign take          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (cnt_reg <= (QW+1)'(QD - 3));
    assign pop_q         = m_axis_tvalid && m_axis_tready;

    // Parent code from the current top, before this byte's push or pop
    logic [7:0] cur_parent;
    assign cur_parent = top_valid ? top.idx : NO_PARENT;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h20;
    endfunction

    // Scanner
    always_comb
    begin
        logic [7:0]  c;
        logic [15:0] pos;
        logic        norm, tokfull, prim_end;
        mode_t       m;
        logic [2:0]  status;
        logic [7:0]  par;
        logic        popd, bumpd;
        c = s_axis_tdata;
        pos = pos_reg;
        m = mode_reg;
        nres = 2'd0;
        r[0] = '0; r[1] = '0; r[2] = '0;
        op = '0;
        op.push_entry.idx = 8'(used_reg);
        op.push_entry.is_array = (c == "[");
        op.push_entry.cnt = 7'd0;
        op.push_entry.start = pos;
        used_next = used_reg;
        pend_next = pend_reg;
        tokfull = (used_reg >= TW'(MAX_TOKENS));
        norm = 1'b0;
        prim_end = 1'b0;
        status = K_OK;
        popd = 1'b0;
        bumpd = 1'b0;
        par = cur_parent;
        if (mode_reg == M_NORMAL || mode_reg == M_STRING || mode_reg == M_ESCAPE
            || mode_reg == M_PRIM)
        begin
            if (pos >= POS_LIMIT)
            begin
                m = M_ERR_IN;
            end
            else
            begin
                unique case (mode_reg)
                    M_NORMAL: norm = 1'b1;
                    M_STRING:
                    begin
                        if (c == "\"")
                        begin
                            if (tokfull)
                            begin
                                m = M_ERR_NM;
                            end
                            else
                            begin
                                r[0].kind = K_TOKEN;
                                r[0].token_index = 7'(used_reg);
                                r[0].token_type = T_STRING;
                                r[0].token_start = pend_reg;
                                r[0].token_end = pos;
                                r[0].parent_index = cur_parent;
                                nres = 2'd1;
                                used_next = used_reg + TW'(1);
                                op.bump = 1'b1;
                                m = M_NORMAL;
                            end
                        end
                        else if (c == "\\")
                        begin
                            m = M_ESCAPE;
                        end
                    end
                    M_ESCAPE:
                    begin
                        if (c == "\"" || c == "/" || c == "\\" || c == "b" || c == "f"
                            || c == "r" || c == "n" || c == "t" || c == "u")
                            m = M_STRING;
                        else
                            m = M_ERR_IN;
                    end
                    M_PRIM:
                    begin
                        prim_end = is_space(c) || c == "," || c == "]" || c == "}"
                                   || (c == ":" && !strict_reg);
                        if (prim_end)
                        begin
                            if (tokfull)
                            begin
                                m = M_ERR_NM;
                            end
                            else
                            begin
                                r[0].kind = K_TOKEN;
                                r[0].token_index = 7'(used_reg);
                                r[0].token_type = T_PRIM;
                                r[0].token_start = pend_reg;
                                r[0].token_end = pos;
                                r[0].parent_index = cur_parent;
                                nres = 2'd1;
                                used_next = used_reg + TW'(1);
                                op.bump = 1'b1;
                                bumpd = 1'b1;
                                norm = 1'b1;
                            end
                        end
                        else if (c < 8'd32 || c >= 8'd127)
                        begin
                            m = M_ERR_IN;
                        end
                    end
                    default: m = mode_reg;
                endcase
            end
        end
        // Normal-mode byte handling, possibly after a primitive closed
        if (norm)
        begin
            m = M_NORMAL;
            if (c == "{" || c == "[")
            begin
                // a primitive cannot end on an opening bracket, so no bump before
                if (tokfull || full)
                begin
                    m = M_ERR_NM;
                end
                else
                begin
                    op.push = 1'b1;
                    op.bump = 1'b1;
                    used_next = used_reg + TW'(1);
                end
            end
            else if (c == "}" || c == "]")
            begin
                if (!top_valid || top.is_array != (c == "]"))
                begin
                    m = M_ERR_IN;
                end
                else
                begin
                    r[nres].kind = K_TOKEN;
                    r[nres].token_index = 7'(top.idx);
                    r[nres].token_type = (c == "]") ? T_ARRAY : T_OBJECT;
                    r[nres].token_start = top.start;
                    r[nres].token_end = pos + 16'd1;
                    r[nres].child_count = (bumpd && top.cnt != 7'd127)
                                          ? top.cnt + 7'd1 : top.cnt;
                    op.pop = 1'b1;
                    popd = 1'b1;
                    nres = nres + 2'd1;
                end
            end
            else if (c == "\"")
            begin
                pend_next = pos + 16'd1;
                m = M_STRING;
            end
            else if (is_space(c) || c == ":" || c == ",")
            begin
                m = M_NORMAL;
            end
            else if (strict_reg ? !(c == "-" || (c >= "0" && c <= "9") || c == "t"
                                    || c == "f" || c == "n")
                                : (c < 8'd32 || c >= 8'd127))
            begin
                m = M_ERR_IN;
            end
            else
            begin
                pend_next = pos;
                m = M_PRIM;
            end
        end
        // Parent after a pop is the entry under the top
        if (popd)
        begin
            par = under_valid ? under.idx : NO_PARENT;
            r[nres-2'd1].parent_index = par;
        end
        pos_next = (pos_reg < POS_LIMIT) ? pos_reg + 16'd1 : pos_reg;
        if (s_axis_tlast)
        begin
            if (m == M_ERR_IN || m == M_ESCAPE)       status = K_INVAL;
            else if (m == M_ERR_NM)                   status = K_NOMEM;
            else if (m == M_STRING)                   status = K_PART;
            else if (m == M_PRIM && strict_reg)       status = K_PART;
            else if (m == M_PRIM && used_next >= TW'(MAX_TOKENS)) status = K_NOMEM;
            else
            begin
                if (m == M_PRIM)
                begin
                    r[nres].kind = K_TOKEN;
                    r[nres].token_index = 7'(used_next);
                    r[nres].token_type = T_PRIM;
                    r[nres].token_start = pend_next;
                    r[nres].token_end = pos_next;
                    r[nres].parent_index = top_valid ? top.idx : NO_PARENT;
                    nres = nres + 2'd1;
                end
                status = (top_valid && !(popd && !under_valid)) || op.push
                         ? K_PART : K_OK;
            end
            r[nres] = '0;
            r[nres].kind = status;
            nres = nres + 2'd1;
            op.clear = 1'b1;
            m = M_NORMAL;
            used_next = '0;
            pos_next = '0;
            pend_next = '0;
        end
        if (nres != 2'd0)
        begin
            r[nres-2'd1].last_of_run = 1'b1;
        end
        mode_next = m;
        if (!take)
        begin
            op = '0;
            nres = 2'd0;
        end
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NORMAL;
            pos_reg  <= '0;
            used_reg <= '0;
            pend_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            used_reg <= used_next;
            pend_reg <= pend_next;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + QW'(nres);
            rp_reg  <= rp_reg + QW'(pop_q);
            cnt_reg <= cnt_reg + (QW+1)'(nres) - (QW+1)'(pop_q);
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < nres)
            begin
                q[wp_reg + QW'(k)] <= r[k];
            end
        end
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tuser  = q[rp_reg].kind;
    assign m_axis_tlast  = q[rp_reg].last_of_run;
    assign m_axis_tdata  = {8'd0, q[rp_reg].parent_index, q[rp_reg].child_count,
                            q[rp_reg].token_end, q[rp_reg].token_start,
                            q[rp_reg].token_type, q[rp_reg].token_index};

endmodule

// ===== tb/json_tokenizer_test.sv =====
// Self-checking bench for the streaming JSON tokenizer: bytes in, token and status items out.
// Depends on jtok_pkg and the json_tokenizer top level; a scoreboard class predicts every item.
`timescale 1ns / 100ps

module json_tokenizer_test
    import jtok_pkg::*;
();

    localparam int TOKEN_CAP = DefMaxTokens;
    localparam int NUM_DEPTH  = DefMaxDepth;
    localparam int CYCLE_LIMIT = 100000;

    typedef enum int {
        SC_NORMAL,
        SC_STRING,
        SC_ESCAPE,
        SC_PRIM,
        SC_BAD,
        SC_FULL
    } scan_t;

    typedef struct {
        logic [2:0]  kind;
        logic [6:0]  token_index;
        logic [1:0]  token_type;
        logic [15:0] token_start;
        logic [15:0] token_end;
        logic [6:0]  child_count;
        logic [7:0]  parent_index;
        logic        last_of_run;
    } item_t;

    typedef struct {
        logic [7:0]  idx;
        logic        is_array;
        logic [6:0]  cnt;
        logic [15:0] start;
    } open_t;

    // Tokenizer predictor plus the queue of expected output items
    class token_scoreboard;
        bit     strict;
        scan_t  scan;
        int     position;
        int     used;
        int     str_start;
        open_t  opens[$];
        item_t  pending[$];
        int     errors;

        function new();
            strict = 0;
            errors = 0;
            clear();
        endfunction

        function void clear();
            scan = SC_NORMAL;
            position = 0;
            used = 0;
            str_start = 0;
            opens.delete();
        endfunction

        function void push_item(logic [2:0] k, int idx, logic [1:0] t, int s, int e,
                                int cnt, logic [7:0] par);
            item_t it;
            it.kind = k;
            it.token_index = idx[6:0];
            it.token_type = t;
            it.token_start = s[15:0];
            it.token_end = e[15:0];
            it.child_count = cnt[6:0];
            it.parent_index = par;
            it.last_of_run = 0;
            pending.push_back(it);
        endfunction

        function logic [7:0] parent_of();
            if (opens.size() == 0)
                return NO_PARENT;
            return opens[opens.size() - 1].idx;
        endfunction

        function void count_child();
            if (opens.size() != 0 && opens[opens.size() - 1].cnt != 7'd127)
                opens[opens.size() - 1].cnt++;
        endfunction

        function bit leaf(logic [1:0] t, int s, int e);
            if (used >= TOKEN_CAP)
                return 0;
            push_item(K_TOKEN, used, t, s, e, 0, parent_of());
            used++;
            count_child();
            return 1;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h09 || c == 8'h0D || c == 8'h0A || c == " ";
        endfunction

        function scan_t normal_byte(logic [7:0] c, int pos);
            open_t o;
            logic  want_array;
            if (c == "{" || c == "[")
            begin
                if (used >= TOKEN_CAP || opens.size() >= NUM_DEPTH)
                    return SC_FULL;
                count_child();
                o.idx = used[7:0];
                o.is_array = (c == "[");
                o.cnt = 0;
                o.start = pos[15:0];
                opens.push_back(o);
                used++;
                return SC_NORMAL;
            end
            if (c == "}" || c == "]")
            begin
                if (opens.size() == 0)
                    return SC_BAD;
                want_array = (c == "]");
                o = opens[opens.size() - 1];
                if (o.is_array != want_array)
                    return SC_BAD;
                void'(opens.pop_back());
                push_item(K_TOKEN, o.idx, want_array ? T_ARRAY : T_OBJECT, o.start, pos + 1,
                          o.cnt, parent_of());
                return SC_NORMAL;
            end
            if (c == "\"")
            begin
                str_start = pos + 1;
                return SC_STRING;
            end
            if (is_blank(c) || c == ":" || c == ",")
                return SC_NORMAL;
            if (strict)
            begin
                if (!(c == "-" || (c >= "0" && c <= "9") || c == "t" || c == "f" || c == "n"))
                    return SC_BAD;
            end
            else if (c < 8'd32 || c >= 8'd127)
                return SC_BAD;
            str_start = pos;
            return SC_PRIM;
        endfunction

        // Predict the items one accepted byte produces
        function void note_byte(logic [7:0] c, logic last);
            int pos;
            int first;
            logic [2:0] status;
            pos = position;
            first = pending.size();
            if (scan == SC_NORMAL || scan == SC_STRING || scan == SC_ESCAPE || scan == SC_PRIM)
            begin
                if (pos >= 65535)
                    scan = SC_BAD;
                else if (scan == SC_NORMAL)
                    scan = normal_byte(c, pos);
                else if (scan == SC_STRING)
                begin
                    if (c == "\"")
                        scan = leaf(T_STRING, str_start, pos) ? SC_NORMAL : SC_FULL;
                    else if (c == "\\")
                        scan = SC_ESCAPE;
                end
                else if (scan == SC_ESCAPE)
                begin
                    if (c == "\"" || c == "/" || c == "\\" || c == "b" || c == "f" ||
                        c == "r" || c == "n" || c == "t" || c == "u")
                        scan = SC_STRING;
                    else
                        scan = SC_BAD;
                end
                else
                begin
                    if (is_blank(c) || c == "," || c == "]" || c == "}" || (c == ":" && !strict))
                    begin
                        if (leaf(T_PRIM, str_start, pos))
                            scan = normal_byte(c, pos);
                        else
                            scan = SC_FULL;
                    end
                    else if (c < 8'd32 || c >= 8'd127)
                        scan = SC_BAD;
                end
            end
            if (position < 65535)
                position++;
            if (last)
            begin
                if (scan == SC_BAD || scan == SC_ESCAPE)
                    status = K_INVAL;
                else if (scan == SC_FULL)
                    status = K_NOMEM;
                else if (scan == SC_STRING)
                    status = K_PART;
                else if (scan == SC_PRIM && strict)
                    status = K_PART;
                else if (scan == SC_PRIM && !leaf(T_PRIM, str_start, position))
                    status = K_NOMEM;
                else
                    status = (opens.size() != 0) ? K_PART : K_OK;
                push_item(status, 0, 0, 0, 0, 0, 8'h00);
                clear();
            end
            if (pending.size() > first)
                pending[pending.size() - 1].last_of_run = 1;
        endfunction

        // Compare one output item with the oldest expectation
        function void check_item(logic [2:0] k, logic [63:0] d, logic l);
            item_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected item kind=%0d data=%h", k, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (k !== x.kind) begin $error("kind exp %0d got %0d", x.kind, k); errors++; end
            if (d[6:0] !== x.token_index)
            begin
                $error("token_index exp %0d got %0d", x.token_index, d[6:0]);
                errors++;
            end
            if (d[8:7] !== x.token_type)
            begin
                $error("token_type exp %0d got %0d", x.token_type, d[8:7]);
                errors++;
            end
            if (d[24:9] !== x.token_start)
            begin
                $error("token_start exp %0d got %0d", x.token_start, d[24:9]);
                errors++;
            end
            if (d[40:25] !== x.token_end)
            begin
                $error("token_end exp %0d got %0d", x.token_end, d[40:25]);
                errors++;
            end
            if (d[47:41] !== x.child_count)
            begin
                $error("child_count exp %0d got %0d", x.child_count, d[47:41]);
                errors++;
            end
            if (d[55:48] !== x.parent_index)
            begin
                $error("parent_index exp %0d got %0d", x.parent_index, d[55:48]);
                errors++;
            end
            if (d[63:56] !== 8'h00)
            begin
                $error("zero fill exp 0 got %h", d[63:56]);
                errors++;
            end
            if (l !== x.last_of_run)
            begin
                $error("last_of_run exp %0d got %0d", x.last_of_run, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;  // text_byte
    logic        s_axis_tlast = 0;  // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;      // token fields, see block port list
    logic [2:0]  m_axis_tuser;      // kind
    logic        m_axis_tlast;      // last_of_run

    token_scoreboard board = new();
    int  cycles = 0;
    bit  stall_req = 0;
    bit  stall_on = 0;
    bit  sender_busy = 0;
    byte doc[$];

    json_tokenizer uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 clk = ~clk;

    function int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 30);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Long receiver stall, counted in cycles here
    initial
    begin
        wait (stall_req);
        @(posedge clk);
        stall_on <= 1;
        repeat (300) @(posedge clk);
        stall_on <= 0;
    end

    // Receiver: random ready, check on each accepted item
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_item(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (stall_on)
            m_axis_tready <= 0;
        else
            m_axis_tready <= ($urandom_range(0, 9) < 7) || !sender_busy && board.pending.size() > 0 && $urandom_range(0, 1);
    end

    // Send one byte and wait for its acceptance
    task automatic send_byte(input logic [7:0] c, input logic last, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        do @(posedge clk); while (!s_axis_tready);
        board.note_byte(c, last);
    endtask

    task automatic send_doc(input bit gaps);
        sender_busy = 1;
        foreach (doc[i])
            send_byte(doc[i], i == doc.size() - 1, gaps);
        s_axis_tvalid <= 0;
        @(posedge clk);
        sender_busy = 0;
    endtask

    task automatic set_text(input string s);
        doc.delete();
        for (int i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_strict(input logic v);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        board.strict = v;
        cfg_valid <= 0;
    endtask

    // Random piece of JSON text, mostly well formed
    function automatic void add_value(int depth);
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (depth < 4 && pick < 3)
        begin
            doc.push_back(pick == 0 ? "[" : "{");
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                if (i > 0) doc.push_back(",");
                if ($urandom_range(0, 3) == 0) doc.push_back(" ");
                if (pick != 0)
                begin
                    doc.push_back("\""); doc.push_back("k"); doc.push_back("\"");
                    doc.push_back(":");
                end
                add_value(depth + 1);
            end
            doc.push_back(pick == 0 ? "]" : "}");
        end
        else if (pick < 6)
        begin
            doc.push_back("\"");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                if ($urandom_range(0, 5) == 0)
                begin
                    doc.push_back("\\");
                    doc.push_back($urandom_range(0, 1) ? "n" : "u");
                end
                else
                    doc.push_back($urandom_range(8'h20, 8'hFF) == "\"" ? "a"
                                  : $urandom_range(8'h20, 8'h7E));
            doc.push_back("\"");
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: doc.push_back("t");
                1: doc.push_back("-");
                2: doc.push_back("x");
                default: doc.push_back("7");
            endcase
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                doc.push_back($urandom_range("0", "9"));
        end
    endfunction

    function automatic void random_doc();
        int r;
        doc.delete();
        add_value(0);
        r = $urandom_range(0, 9);
        // Corrupt some documents: noise byte, truncation or an appended random byte
        if (r == 0)
            doc[$urandom_range(0, doc.size() - 1)] = $urandom_range(0, 255);
        else if (r == 1 && doc.size() > 1)
            void'(doc.pop_back());
        else if (r == 2)
            doc.push_back($urandom_range(0, 255));
    endfunction

    initial
    begin
        int sent;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: nesting, every token type, escapes, errors, status kinds
        set_text("{\"a\":[1,-2,true],\"b\\n\":null}"); send_doc(0);
        set_text("[]]"); send_doc(0);
        set_text("[}"); send_doc(0);
        set_text("\"ab\\q\""); send_doc(1);
        set_text("\"open"); send_doc(1);
        set_text("\"x\\"); send_doc(0);
        set_text("[1,{"); send_doc(0);
        set_text("abc:def 42"); send_doc(0);
        doc.delete(); doc.push_back(8'h00); doc.push_back(8'hFF); send_doc(0);
        doc.delete(); doc.push_back(8'h7F); send_doc(0);
        doc.delete();
        for (int i = 0; i < NUM_DEPTH + 1; i++) doc.push_back("[");
        send_doc(0);
        set_text(" \t\r\n7"); send_doc(0);
        drain();
        write_strict(1);
        set_text("[x]"); send_doc(0);
        set_text("[12:3]"); send_doc(0);
        set_text("-5"); send_doc(0);
        set_text("[false, null]"); send_doc(1);
        drain();
        write_strict(0);

        // Token exhaustion: many small primitives in one array
        doc.delete(); doc.push_back("[");
        for (int i = 0; i < TOKEN_CAP; i++) begin doc.push_back("1"); doc.push_back(","); end
        doc.push_back("]");
        send_doc(0);
        drain();

        // Long stall on the receiver while bytes keep coming
        stall_req = 1;
        set_text("[1,2,3,4,5,6,7,8,9,0,1,2,3,4,5,6,7,8,9,0,1,2,3]"); send_doc(0);

        // Random documents, switching strict mode between phases
        sent = 0;
        for (int ph = 0; sent < 60; ph++)
        begin
            for (int d = 0; d < 8 && sent < 60; d++)
            begin
                random_doc();
                sent += doc.size();
                send_doc(ph % 3 != 2);
            end
            drain();
            write_strict($urandom_range(0, 1));
        end
        drain();
        repeat (20) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
